FILE: rtl/assert_macros.svh
// Assertion macros used by the port-level checker.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold in the same cycle.
`define STMS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("stms assertion failed");

// Antecedent implies consequent in the next cycle.
`define STMS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("stms assertion failed");

`endif

FILE: rtl/stms_pkg.sv
// Shared types and constants for the sorted table membership search block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package stms_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int KEY_W       = 32;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [1:0] {
      FUNC_LOAD   = 2'd0,
      FUNC_SEARCH = 2'd1,
      FUNC_CLEAR  = 2'd2
   } func_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SORT_RD_S,
      ST_SORT_LD_S,
      ST_SORT_RD_I,
      ST_SORT_CMP_I,
      ST_SORT_WR_LO,
      ST_SORT_WR_S,
      ST_SRCH_ADDR,
      ST_SRCH_CMP,
      ST_RESP
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic accept;
      logic drop;
      logic load;
      logic clear;
      logic rd_s;
      logic ld_s;
      logic rd_i;
      logic cmp_i;
      logic wr_lo;
      logic wr_s;
      logic probe;
      logic check;
   } ctl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic full;
      logic need_sort;
      logic i_last;
      logic s_last;
      logic in_range;
      logic hit;
   } dp_status_type;

endpackage

`default_nettype wire

FILE: rtl/stms_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module stms_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/stms_ctrl.sv
// Controller state machine: sequences load, clear, selection sort and binary search.
// Depends on stms_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stms_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic [1:0]               req_func,
   input  wire stms_pkg::dp_status_type  dp_status,
   output stms_pkg::ctl_cmd_type         ctl_cmd,
   output logic                          busy,
   output logic                          rsp_valid
);

   stms_pkg::state_type state_ff;
   stms_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= stms_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         stms_pkg::ST_IDLE: begin
            if (start) begin
               if (stms_pkg::func_type'(req_func) == stms_pkg::FUNC_SEARCH) begin
                  state_in = dp_status.need_sort ? stms_pkg::ST_SORT_RD_S
                                                 : stms_pkg::ST_SRCH_ADDR;
               end else begin
                  state_in = stms_pkg::ST_RESP;
               end
            end
         end
         stms_pkg::ST_SORT_RD_S:  state_in = stms_pkg::ST_SORT_LD_S;
         stms_pkg::ST_SORT_LD_S:  state_in = stms_pkg::ST_SORT_RD_I;
         stms_pkg::ST_SORT_RD_I:  state_in = stms_pkg::ST_SORT_CMP_I;
         stms_pkg::ST_SORT_CMP_I: begin
            state_in = dp_status.i_last ? stms_pkg::ST_SORT_WR_LO : stms_pkg::ST_SORT_RD_I;
         end
         stms_pkg::ST_SORT_WR_LO: state_in = stms_pkg::ST_SORT_WR_S;
         stms_pkg::ST_SORT_WR_S: begin
            state_in = dp_status.s_last ? stms_pkg::ST_SRCH_ADDR : stms_pkg::ST_SORT_RD_S;
         end
         stms_pkg::ST_SRCH_ADDR: begin
            state_in = dp_status.in_range ? stms_pkg::ST_SRCH_CMP : stms_pkg::ST_RESP;
         end
         stms_pkg::ST_SRCH_CMP: begin
            state_in = dp_status.hit ? stms_pkg::ST_RESP : stms_pkg::ST_SRCH_ADDR;
         end
         stms_pkg::ST_RESP:       state_in = stms_pkg::ST_IDLE;
         default:                 state_in = stms_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      ctl_cmd   = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         stms_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               ctl_cmd.accept = 1'b1;
               case (stms_pkg::func_type'(req_func))
                  stms_pkg::FUNC_LOAD: begin
                     ctl_cmd.drop = dp_status.full;
                     ctl_cmd.load = !dp_status.full;
                  end
                  stms_pkg::FUNC_CLEAR:  ctl_cmd.clear = 1'b1;
                  stms_pkg::FUNC_SEARCH: ;
                  default: ;
               endcase
            end
         end
         stms_pkg::ST_SORT_RD_S:  ctl_cmd.rd_s  = 1'b1;
         stms_pkg::ST_SORT_LD_S:  ctl_cmd.ld_s  = 1'b1;
         stms_pkg::ST_SORT_RD_I:  ctl_cmd.rd_i  = 1'b1;
         stms_pkg::ST_SORT_CMP_I: ctl_cmd.cmp_i = 1'b1;
         stms_pkg::ST_SORT_WR_LO: ctl_cmd.wr_lo = 1'b1;
         stms_pkg::ST_SORT_WR_S:  ctl_cmd.wr_s  = 1'b1;
         stms_pkg::ST_SRCH_ADDR:  ctl_cmd.probe = dp_status.in_range;
         stms_pkg::ST_SRCH_CMP:   ctl_cmd.check = 1'b1;
         stms_pkg::ST_RESP:       rsp_valid     = 1'b1;
         default: ;
      endcase
   end

endmodule

`default_nettype wire

FILE: rtl/stms_datapath.sv
// Datapath: key table RAM, fill count, sort pointers and search bounds.
// Depends on stms_pkg and stms_ram.
`timescale 1ns / 1ps
`default_nettype none

module stms_datapath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic signed [stms_pkg::KEY_W-1:0]   req_key,
   input  wire stms_pkg::ctl_cmd_type               ctl_cmd,
   output stms_pkg::dp_status_type                  dp_status,
   output logic                                     rsp_status,
   output logic                                     rsp_found,
   output logic        [stms_pkg::IDX_W-1:0]        rsp_position,
   output logic        [stms_pkg::CNT_W-1:0]        rsp_entries
);

   localparam int IW = stms_pkg::IDX_W;
   localparam int CW = stms_pkg::CNT_W;
   localparam int KW = stms_pkg::KEY_W;

   logic [CW-1:0]        count_ff,  count_in;
   logic                 sorted_ff, sorted_in;
   logic [IW-1:0]        s_ff, s_in;
   logic [IW-1:0]        i_ff, i_in;
   logic [IW-1:0]        lo_ff, lo_in;
   logic signed [KW-1:0] lv_ff, lv_in;
   logic signed [KW-1:0] sv_ff, sv_in;
   logic signed [KW-1:0] key_ff, key_in;
   logic [CW-1:0]        first_ff, first_in;
   logic [CW-1:0]        lastp1_ff, lastp1_in;
   logic [IW-1:0]        mid_ff, mid_in;
   logic                 status_ff, status_in;
   logic                 found_ff, found_in;
   logic [IW-1:0]        pos_ff, pos_in;

   logic                 wr_en;
   logic [IW-1:0]        wr_addr;
   logic [KW-1:0]        wr_data;
   logic [IW-1:0]        rd_addr;
   logic [KW-1:0]        rd_data;
   logic signed [KW-1:0] rd_key;
   logic [CW:0]          mid_sum;
   logic [IW-1:0]        mid_next;

   stms_ram #(
      .WIDTH (KW),
      .DEPTH (stms_pkg::TABLE_DEPTH)
   ) u_key_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_key = $signed(rd_data);

   // (first + last) / 2 with last = lastp1 - 1; only used while first < lastp1
   assign mid_sum  = {1'b0, first_ff} + {1'b0, lastp1_ff} - (CW+1)'(1);
   assign mid_next = mid_sum[IW:1];

   always_comb begin
      wr_en   = ctl_cmd.load | ctl_cmd.wr_lo | ctl_cmd.wr_s;
      wr_addr = s_ff;
      wr_data = lv_ff;
      if (ctl_cmd.load) begin
         wr_addr = count_ff[IW-1:0];
         wr_data = req_key;
      end else if (ctl_cmd.wr_lo) begin
         wr_addr = lo_ff;
         wr_data = sv_ff;
      end
      rd_addr = mid_next;
      if (ctl_cmd.rd_s) begin
         rd_addr = s_ff;
      end else if (ctl_cmd.rd_i) begin
         rd_addr = i_ff;
      end
   end

   always_comb begin
      dp_status.full      = (count_ff == CW'(stms_pkg::TABLE_DEPTH));
      dp_status.need_sort = !sorted_ff && (count_ff >= CW'(2));
      dp_status.i_last    = (CW'(i_ff) + CW'(1) == count_ff);
      dp_status.s_last    = (CW'(s_ff) + CW'(2) == count_ff);
      dp_status.in_range  = (first_ff < lastp1_ff);
      dp_status.hit       = (rd_key == key_ff);
   end

   always_comb begin
      count_in  = count_ff;
      sorted_in = sorted_ff;
      s_in      = s_ff;
      i_in      = i_ff;
      lo_in     = lo_ff;
      lv_in     = lv_ff;
      sv_in     = sv_ff;
      key_in    = key_ff;
      first_in  = first_ff;
      lastp1_in = lastp1_ff;
      mid_in    = mid_ff;
      status_in = status_ff;
      found_in  = found_ff;
      pos_in    = pos_ff;

      if (ctl_cmd.accept) begin
         key_in    = req_key;
         s_in      = '0;
         first_in  = '0;
         lastp1_in = count_ff;
         status_in = ctl_cmd.drop;
         found_in  = 1'b0;
         pos_in    = '0;
      end
      if (ctl_cmd.load) begin
         count_in  = count_ff + CW'(1);
         sorted_in = 1'b0;
      end
      if (ctl_cmd.clear) begin
         count_in  = '0;
         sorted_in = 1'b1;
      end
      if (ctl_cmd.ld_s) begin
         lv_in = rd_key;
         sv_in = rd_key;
         lo_in = s_ff;
         i_in  = s_ff + IW'(1);
      end
      if (ctl_cmd.cmp_i) begin
         if (rd_key < lv_ff) begin
            lv_in = rd_key;
            lo_in = i_ff;
         end
         i_in = i_ff + IW'(1);
      end
      if (ctl_cmd.wr_s) begin
         s_in = s_ff + IW'(1);
         if (dp_status.s_last) begin
            sorted_in = 1'b1;
         end
      end
      if (ctl_cmd.probe) begin
         mid_in = mid_next;
      end
      if (ctl_cmd.check) begin
         if (dp_status.hit) begin
            found_in = 1'b1;
            pos_in   = mid_ff;
         end else if (key_ff < rd_key) begin
            lastp1_in = CW'(mid_ff);
         end else begin
            first_in = CW'(mid_ff) + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         sorted_ff <= 1'b1;
      end else begin
         count_ff  <= count_in;
         sorted_ff <= sorted_in;
      end
   end

   always_ff @(posedge clock) begin
      s_ff      <= s_in;
      i_ff      <= i_in;
      lo_ff     <= lo_in;
      lv_ff     <= lv_in;
      sv_ff     <= sv_in;
      key_ff    <= key_in;
      first_ff  <= first_in;
      lastp1_ff <= lastp1_in;
      mid_ff    <= mid_in;
      status_ff <= status_in;
      found_ff  <= found_in;
      pos_ff    <= pos_in;
   end

   assign rsp_status   = status_ff;
   assign rsp_found    = found_ff;
   assign rsp_position = pos_ff;
   assign rsp_entries  = count_ff;

endmodule

`default_nettype wire

FILE: rtl/sorted_table_membership_search.sv
// Load, clear, and search a table of up to 16 signed 32-bit keys. An item is taken when start
// is high and busy is low; its result shows on the rsp_ ports for exactly one cycle with
// rsp_valid high and must be captured then. Load, clear and the unused code go from idle
// straight to the response state. A search alternates an address state and a compare state
// for each probe, since every probe reads the key RAM and waits for its registered data, and
// a miss ends when the bounds cross. The first search after loads, with two or more keys held,
// first sorts the table by selection sort.
// Depends on stms_pkg, stms_ctrl, stms_datapath, stms_ram.
`timescale 1ns / 1ps
`default_nettype none

module sorted_table_membership_search (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [1:0]                        req_func,
   input  wire logic signed [stms_pkg::KEY_W-1:0] req_key,
   output logic                                   rsp_valid,
   output logic                                   rsp_status,
   output logic                                   rsp_found,
   output logic [stms_pkg::IDX_W-1:0]             rsp_position,
   output logic [stms_pkg::CNT_W-1:0]             rsp_entries
);

   stms_pkg::ctl_cmd_type   ctl_cmd;
   stms_pkg::dp_status_type dp_status;

   stms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_func  (req_func),
      .dp_status (dp_status),
      .ctl_cmd   (ctl_cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   stms_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_key      (req_key),
      .ctl_cmd      (ctl_cmd),
      .dp_status    (dp_status),
      .rsp_status   (rsp_status),
      .rsp_found    (rsp_found),
      .rsp_position (rsp_position),
      .rsp_entries  (rsp_entries)
   );

endmodule

`default_nettype wire

FILE: rtl/stms_checker.sv
// Port-level checks for the sorted table membership search block, bound to the top level.
// Depends on stms_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module stms_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              start,
   input wire logic                              busy,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_status,
   input wire logic                              rsp_found,
   input wire logic [stms_pkg::IDX_W-1:0]        rsp_position,
   input wire logic [stms_pkg::CNT_W-1:0]        rsp_entries
);

   `STMS_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `STMS_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_valid, !rsp_valid && !busy)
   `STMS_ASSERT(a_entries_range, clock, reset, !rsp_valid || rsp_entries <= stms_pkg::CNT_W'(stms_pkg::TABLE_DEPTH))
   `STMS_ASSERT(a_drop_not_found, clock, reset, !(rsp_valid && rsp_status && rsp_found))
   `STMS_ASSERT(a_miss_pos_zero, clock, reset, !rsp_valid || rsp_found || rsp_position == '0)

endmodule

bind sorted_table_membership_search stms_checker u_stms_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .rsp_valid    (rsp_valid),
   .rsp_status   (rsp_status),
   .rsp_found    (rsp_found),
   .rsp_position (rsp_position),
   .rsp_entries  (rsp_entries)
);

`default_nettype wire

FILE: verif/stms_checker.sv
// Checker for the sorted table membership search block: follows the item and result
// channels, keeps its own copy of the key table and scores every result.
// Depends on stms_pkg.
`timescale 1ns / 1ps

module stms_scoreboard
   import stms_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic                     busy,
   input  wire logic [1:0]               req_func,
   input  wire logic signed [KEY_W-1:0]  req_key,
   input  wire logic                     rsp_valid,
   input  wire logic                     rsp_status,
   input  wire logic                     rsp_found,
   input  wire logic [IDX_W-1:0]         rsp_position,
   input  wire logic [CNT_W-1:0]         rsp_entries,
   output int                            errors,
   output int                            pending,
   output int                            hits,
   output int                            drops
);

   typedef struct packed {
      logic             status;
      logic             found;
      logic [IDX_W-1:0] position;
      logic [CNT_W-1:0] entries;
   } lookup_result_type;

   logic signed [KEY_W-1:0] table_keys [TABLE_DEPTH];
   int                      held_count = 0;
   bit                      ordered = 1'b1;
   lookup_result_type       result_q [$];

   function automatic void order_keys();
      int                      s, i, lo_idx;
      logic signed [KEY_W-1:0] lo_val;
      for (s = 0; s + 1 < held_count; s++) begin
         lo_idx = s;
         lo_val = table_keys[s];
         for (i = s + 1; i < held_count; i++) begin
            if (table_keys[i] < lo_val) begin
               lo_val = table_keys[i];
               lo_idx = i;
            end
         end
         table_keys[lo_idx] = table_keys[s];
         table_keys[s]      = lo_val;
      end
   endfunction

   function automatic lookup_result_type apply_item(logic [1:0] func,
                                                    logic signed [KEY_W-1:0] key);
      lookup_result_type r;
      int                first, last, mid;
      r = '0;
      case (func)
         FUNC_LOAD: begin
            if (held_count >= TABLE_DEPTH) begin
               r.status = 1'b1;
            end else begin
               table_keys[held_count] = key;
               held_count++;
               ordered = 1'b0;
            end
         end
         FUNC_SEARCH: begin
            if (!ordered) begin
               order_keys();
               ordered = 1'b1;
            end
            first = 0;
            last  = held_count - 1;
            // probe at (first+last)/2, first equal probe wins on duplicates
            while (first <= last && !r.found) begin
               mid = (first + last) / 2;
               if (table_keys[mid] == key) begin
                  r.found    = 1'b1;
                  r.position = IDX_W'(mid);
               end else if (key < table_keys[mid]) begin
                  last = mid - 1;
               end else begin
                  first = mid + 1;
               end
            end
         end
         FUNC_CLEAR: begin
            held_count = 0;
            ordered    = 1'b1;
         end
         default: ;
      endcase
      r.entries = CNT_W'(held_count);
      return r;
   endfunction

   always @(posedge clock) begin
      lookup_result_type want, got, nxt;
      if (reset) begin
         held_count = 0;
         ordered    = 1'b1;
         result_q.delete();
         errors  <= 0;
         pending <= 0;
         hits    <= 0;
         drops   <= 0;
      end else begin
         if (rsp_valid) begin
            got = '{rsp_status, rsp_found, rsp_position, rsp_entries};
            if (result_q.size() == 0) begin
               $display("%0t unexpected result: status %0b found %0b position %0d entries %0d",
                        $time, rsp_status, rsp_found, rsp_position, rsp_entries);
               errors <= errors + 1;
            end else begin
               want = result_q.pop_front();
               if (got !== want) begin
                  $display("%0t mismatch: expected status %0b found %0b position %0d entries %0d",
                           $time, want.status, want.found, want.position, want.entries);
                  $display("%0t          actual   status %0b found %0b position %0d entries %0d",
                           $time, got.status, got.found, got.position, got.entries);
                  errors <= errors + 1;
               end
            end
         end
         if (start && !busy) begin
            nxt = apply_item(req_func, req_key);
            result_q = {result_q, nxt};
            hits  <= hits + nxt.found;
            drops <= drops + nxt.status;
         end
         pending <= result_q.size();
      end
   end

endmodule

FILE: verif/sorted_table_membership_search_tb.sv
// Top of the sorted table membership search testbench: clock, reset, item stimulus with
// bursts and gaps, and the verdict. Depends on stms_pkg, stms_scoreboard and the block.
`timescale 1ns / 1ps

module sorted_table_membership_search_tb;
   import stms_pkg::*;

   localparam logic [1:0] FUNC_UNUSED  = 2'd3;
   localparam int         RANDOM_ITEMS = 800;
   localparam int         CYCLE_LIMIT  = 1_000_000;
   localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic [1:0]              req_func = FUNC_LOAD;
   logic signed [KEY_W-1:0] req_key = '0;
   logic                    busy;
   logic                    rsp_valid;
   logic                    rsp_status;
   logic                    rsp_found;
   logic [IDX_W-1:0]        rsp_position;
   logic [CNT_W-1:0]        rsp_entries;

   int errors, pending, hits, drops;
   int cycle_count = 0;
   int burst_left = 0;
   int n_items = 0, n_loads = 0, n_searches = 0, n_clears = 0, n_unused = 0;

   // keys loaded since the last clear, used to aim searches at hits
   logic signed [KEY_W-1:0] loaded_keys [$];

   always #5 clock = ~clock;

   sorted_table_membership_search uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_func(req_func), .req_key(req_key),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status), .rsp_found(rsp_found),
      .rsp_position(rsp_position), .rsp_entries(rsp_entries)
   );

   stms_scoreboard u_scoreboard (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_func(req_func), .req_key(req_key),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status), .rsp_found(rsp_found),
      .rsp_position(rsp_position), .rsp_entries(rsp_entries),
      .errors(errors), .pending(pending), .hits(hits), .drops(drops)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("sorted_table_membership_search regression: fail");
         $finish;
      end
   end

   // 0: any 32-bit key, 1: narrow range full of duplicates, 2: boundary keys
   function automatic logic signed [KEY_W-1:0] pick_key(int mode);
      case (mode)
         1: return $signed($urandom_range(0, 15)) - 8;
         2: begin
            case ($urandom_range(0, 6))
               0: return KEY_MIN;
               1: return KEY_MAX;
               2: return KEY_MIN + 1;
               3: return KEY_MAX - 1;
               4: return -1;
               5: return 0;
               default: return 1;
            endcase
         end
         default: return $signed($urandom);
      endcase
   endfunction

   function automatic logic signed [KEY_W-1:0] search_target(int mode);
      if (loaded_keys.size() != 0 && $urandom_range(0, 9) < 7)
         return loaded_keys[$urandom_range(0, loaded_keys.size() - 1)];
      return pick_key(mode);
   endfunction

   task automatic send_item(input logic [1:0] func, input logic signed [KEY_W-1:0] key);
      start    <= 1'b1;
      req_func <= func;
      req_key  <= key;
      @(posedge clock);
      while (busy) @(posedge clock);
      n_items++;
      case (func)
         FUNC_LOAD: begin
            n_loads++;
            if (loaded_keys.size() < TABLE_DEPTH) loaded_keys = {loaded_keys, key};
         end
         FUNC_SEARCH: n_searches++;
         FUNC_CLEAR: begin
            n_clears++;
            loaded_keys.delete();
         end
         default: n_unused++;
      endcase
      if (burst_left == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = $urandom_range(1, 40);
      end else begin
         burst_left--;
      end
   endtask

   // hold off until every outstanding result is back
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   initial begin
      int j, n_load, n_search, mode, sent_at_start;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty table, boundary keys, duplicates, misses, full table, clear
      send_item(FUNC_SEARCH, 0);
      send_item(FUNC_UNUSED, KEY_MAX);
      send_item(FUNC_LOAD, KEY_MAX);
      send_item(FUNC_LOAD, KEY_MIN);
      send_item(FUNC_LOAD, -1);
      send_item(FUNC_LOAD, 0);
      send_item(FUNC_LOAD, 5);
      send_item(FUNC_LOAD, 5);
      send_item(FUNC_SEARCH, KEY_MIN);
      send_item(FUNC_SEARCH, KEY_MAX);
      send_item(FUNC_SEARCH, 5);
      send_item(FUNC_SEARCH, 3);
      for (j = 0; j < 10; j++) send_item(FUNC_LOAD, $signed($urandom));
      send_item(FUNC_LOAD, 7);
      send_item(FUNC_SEARCH, -1);
      drain();
      send_item(FUNC_CLEAR, KEY_MIN);
      send_item(FUNC_SEARCH, 5);
      send_item(FUNC_UNUSED, -1);

      // random: mostly load-then-search episodes, some noise items
      sent_at_start = n_items;
      while (n_items - sent_at_start < RANDOM_ITEMS) begin
         if ($urandom_range(0, 9) == 0) begin
            send_item(2'($urandom_range(0, 3)), $signed($urandom));
         end else begin
            mode = $urandom_range(0, 2);
            if ($urandom_range(0, 2) == 0) send_item(FUNC_CLEAR, $signed($urandom));
            n_load = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 18)
                                                 : $urandom_range(1, 6);
            n_search = $urandom_range(1, 6);
            for (j = 0; j < n_load; j++) send_item(FUNC_LOAD, pick_key(mode));
            for (j = 0; j < n_search; j++) send_item(FUNC_SEARCH, search_target(mode));
            if ($urandom_range(0, 19) == 0) drain();
         end
      end

      drain();
      repeat (300) @(posedge clock);
      $display("covered %0d items: %0d loads (%0d refused on a full table), %0d searches",
               n_items, n_loads, drops, n_searches);
      $display("  with %0d hits, %0d clears and %0d unused-code items", hits, n_clears,
               n_unused);
      if (errors == 0) begin
         $display("sorted_table_membership_search regression: pass");
      end else begin
         $display("sorted_table_membership_search regression: fail");
      end
      $finish;
   end

endmodule

FILE: sorted_table_membership_search.f
+incdir+rtl
rtl/stms_pkg.sv
rtl/stms_ram.sv
rtl/stms_ctrl.sv
rtl/stms_datapath.sv
rtl/sorted_table_membership_search.sv
rtl/stms_checker.sv
verif/stms_checker.sv
verif/sorted_table_membership_search_tb.sv
